// File: rtl/cvl_pkg.sv
// cvl_pkg: shared constants, payload structs, codes and control bundles
// for the compacting value list; no dependencies
`default_nettype none

package cvl_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 5;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
      logic [INDEX_W-1:0]        index;
   } req_type;

   typedef struct packed {
      logic                      ok;
      logic signed [DATA_W-1:0]  data;
      logic [COUNT_W-1:0]        count;
      logic                      empty_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GET_WAIT,
      ST_SEARCH,
      ST_COMPARE,
      ST_SHIFT,
      ST_MOVE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_INDEX,
      RD_PTR,
      RD_PTR_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       load_item;
      logic       wr_append;
      logic       wr_shift;
      logic       inc_count;
      logic       dec_count;
      logic       clr_count;
      logic       ptr_clear;
      logic       ptr_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       set_ok;
      logic       set_data_rd;
      logic       set_data_bad;
      logic       result_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   index_ok;
      logic   ptr_end;
      logic   ptr_last;
      logic   match;
      logic   out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/cvl_ram.sv
// cvl_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cvl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/cvl_ctrl.sv
// cvl_ctrl: sequencer for the compacting value list
// depends on cvl_pkg; drives cvl_datapath through cmd_type, reads status_type
`default_nettype none

module cvl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire cvl_pkg::status_type status,
   output cvl_pkg::cmd_type         cmd
);

   cvl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cvl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cvl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = cvl_pkg::ST_DECODE;
            end
         end
         cvl_pkg::ST_DECODE: begin
            unique case (status.op)
               cvl_pkg::OP_APPEND: begin
                  if (!status.full) begin
                     cmd.wr_append = 1'b1;
                     cmd.inc_count = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
                  state_in = cvl_pkg::ST_FINISH;
               end
               cvl_pkg::OP_REMOVE: begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = cvl_pkg::ST_SEARCH;
               end
               cvl_pkg::OP_GET: begin
                  if (status.index_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = cvl_pkg::RD_INDEX;
                     state_in   = cvl_pkg::ST_GET_WAIT;
                  end else begin
                     cmd.set_data_bad = 1'b1;
                     state_in         = cvl_pkg::ST_FINISH;
                  end
               end
               cvl_pkg::OP_CLEAR: begin
                  cmd.clr_count = 1'b1;
                  cmd.set_ok    = 1'b1;
                  state_in      = cvl_pkg::ST_FINISH;
               end
               default: begin
                  state_in = cvl_pkg::ST_FINISH;
               end
            endcase
         end
         cvl_pkg::ST_GET_WAIT: begin
            cmd.set_data_rd = 1'b1;
            cmd.set_ok      = 1'b1;
            state_in        = cvl_pkg::ST_FINISH;
         end
         cvl_pkg::ST_SEARCH: begin
            if (status.ptr_end) begin
               state_in = cvl_pkg::ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = cvl_pkg::RD_PTR;
               state_in   = cvl_pkg::ST_COMPARE;
            end
         end
         cvl_pkg::ST_COMPARE: begin
            if (status.match) begin
               state_in = cvl_pkg::ST_SHIFT;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = cvl_pkg::ST_SEARCH;
            end
         end
         cvl_pkg::ST_SHIFT: begin
            if (status.ptr_last) begin
               cmd.dec_count = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = cvl_pkg::ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = cvl_pkg::RD_PTR_NEXT;
               state_in   = cvl_pkg::ST_MOVE;
            end
         end
         cvl_pkg::ST_MOVE: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_inc  = 1'b1;
            state_in     = cvl_pkg::ST_SHIFT;
         end
         cvl_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = cvl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cvl_pkg::ST_IDLE;
         end
      endcase
   end

   // a result is only loaded when the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> status.out_free)
      else $error("result loaded into an occupied output register");

   // a finished beat sends the sequencer back to idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> (state_ff == cvl_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after a result");

   // the memory is never written and read-searched in the same cycle
   a_wr_rd: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_append || cmd.wr_shift) |-> !cmd.rd_en)
      else $error("write and read issued together");

endmodule

`default_nettype wire

// File: rtl/cvl_datapath.sv
// cvl_datapath: item registers, entry store, count, search pointer and output register
// depends on cvl_pkg and cvl_ram; steered by cvl_ctrl
`default_nettype none

module cvl_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cvl_pkg::req_type    req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output cvl_pkg::rsp_type         rsp_payload,
   input  wire cvl_pkg::cmd_type    cmd,
   output cvl_pkg::status_type      status
);

   cvl_pkg::op_type                     op_ff;
   logic signed [cvl_pkg::DATA_W-1:0]   value_ff;
   logic [cvl_pkg::INDEX_W-1:0]         index_ff;
   logic [cvl_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [cvl_pkg::CNT_W-1:0]           ptr_ff, ptr_in;
   logic                                ok_ff, ok_in;
   logic [cvl_pkg::DATA_W-1:0]          data_ff, data_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   cvl_pkg::rsp_type                    rsp_ff;

   logic [cvl_pkg::CNT_W:0]             ptr_plus;
   logic [cvl_pkg::CMP_W-1:0]           count_wide;
   logic [cvl_pkg::CMP_W-1:0]           index_wide;
   logic                                wr_en;
   logic [cvl_pkg::ADDR_W-1:0]          wr_addr;
   logic [cvl_pkg::DATA_W-1:0]          wr_data;
   logic [cvl_pkg::ADDR_W-1:0]          rd_addr;
   logic [cvl_pkg::DATA_W-1:0]          rd_data;
   logic                                out_free;

   assign ptr_plus   = {1'b0, ptr_ff} + (cvl_pkg::CNT_W + 1)'(1);
   assign count_wide = cvl_pkg::CMP_W'(count_ff);
   assign index_wide = cvl_pkg::CMP_W'(index_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // entry store
   assign wr_en   = cmd.wr_append || cmd.wr_shift;
   assign wr_addr = cmd.wr_shift ? ptr_ff[cvl_pkg::ADDR_W-1:0]
                                 : count_ff[cvl_pkg::ADDR_W-1:0];
   assign wr_data = cmd.wr_shift ? rd_data : value_ff;

   always_comb begin
      case (cmd.rd_sel)
         cvl_pkg::RD_INDEX:    rd_addr = index_wide[cvl_pkg::ADDR_W-1:0];
         cvl_pkg::RD_PTR:      rd_addr = ptr_ff[cvl_pkg::ADDR_W-1:0];
         cvl_pkg::RD_PTR_NEXT: rd_addr = ptr_plus[cvl_pkg::ADDR_W-1:0];
         default:              rd_addr = ptr_ff[cvl_pkg::ADDR_W-1:0];
      endcase
   end

   cvl_ram #(
      .WIDTH (cvl_pkg::DATA_W),
      .DEPTH (cvl_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status back to the sequencer
   assign status.op       = op_ff;
   assign status.full     = (count_ff == cvl_pkg::CNT_W'(cvl_pkg::CAPACITY));
   assign status.index_ok = (index_wide < count_wide);
   assign status.ptr_end  = (ptr_ff >= count_ff);
   assign status.ptr_last = (ptr_plus >= {1'b0, count_ff});
   assign status.match    = (rd_data == value_ff);
   assign status.out_free = out_free;

   always_comb begin
      count_in = count_ff;
      if (cmd.clr_count) begin
         count_in = '0;
      end else if (cmd.inc_count) begin
         count_in = count_ff + cvl_pkg::CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - cvl_pkg::CNT_W'(1);
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_plus[cvl_pkg::CNT_W-1:0];
      end

      ok_in = ok_ff;
      if (cmd.load_item) begin
         ok_in = 1'b0;
      end else if (cmd.set_ok) begin
         ok_in = 1'b1;
      end

      data_in = data_ff;
      if (cmd.load_item) begin
         data_in = '0;
      end else if (cmd.set_data_bad) begin
         data_in = '1;
      end else if (cmd.set_data_rd) begin
         data_in = rd_data;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      ok_ff   <= ok_in;
      data_ff <= data_in;
      if (cmd.load_item) begin
         op_ff    <= req_payload.op;
         value_ff <= req_payload.value;
         index_ff <= req_payload.index;
      end
      if (cmd.result_load) begin
         rsp_ff.ok        <= ok_ff;
         rsp_ff.data      <= data_ff;
         rsp_ff.count     <= count_wide[cvl_pkg::COUNT_W-1:0];
         rsp_ff.empty_res <= (count_ff == '0);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // appends land inside the store
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |-> (count_ff < cvl_pkg::CNT_W'(cvl_pkg::CAPACITY)))
      else $error("append written beyond capacity");

   // compaction moves stay below the count
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_shift |-> (ptr_plus < {1'b0, count_ff}))
      else $error("compaction move outside the list");

   // the count never exceeds capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= cvl_pkg::CNT_W'(cvl_pkg::CAPACITY)))
      else $error("entry count above capacity");

endmodule

`default_nettype wire

// File: rtl/compacting_value_list_top.sv
// Ordered list of up to CAPACITY signed 32-bit entries with append, remove first match,
// get by index and clear; each request beat gives exactly one response beat carrying
// ok, data, the new count and an empty flag. One request is worked on at a time: a
// remove reads the entry store once per entry compared and once per later entry moved
// down, as the registered-read entry store with one write and one read port is read
// once per step of the search and of the compaction. A finished response waits in the
// output register; the next request is accepted meanwhile but cannot load its own
// response until that register is free.
// Depends on cvl_pkg, cvl_ctrl, cvl_datapath and cvl_ram.
`default_nettype none

module compacting_value_list_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cvl_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cvl_pkg::rsp_type      rsp_payload
);

   cvl_pkg::cmd_type    cmd;
   cvl_pkg::status_type status;

   cvl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cvl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// File: dv/compacting_value_list_top_tb.sv
`timescale 1ns / 1ps
// compacting_value_list_top_tb: self-checking bench for the compacting value list,
// predicting every response beat from its own copy of the list and count
// depends on cvl_pkg and compacting_value_list_top

module compacting_value_list_top_tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 4 * cvl_pkg::CAPACITY + 16;
   localparam logic signed [cvl_pkg::DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
   localparam logic signed [cvl_pkg::DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   cvl_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   cvl_pkg::rsp_type rsp_payload;

   logic signed [cvl_pkg::DATA_W-1:0] list_vals [cvl_pkg::CAPACITY];
   int               list_len = 0;
   cvl_pkg::rsp_type pending_answers [$];
   int               error_count = 0;
   int               cycle_count = 0;
   bit               steady_flow = 1'b0;
   int               hold_asks = 0;

   compacting_value_list_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("compacting_value_list_top_tb: errors");
         $finish;
      end
   end

   function automatic cvl_pkg::rsp_type apply_list_op(input cvl_pkg::req_type item);
      cvl_pkg::rsp_type answer;
      int               pos;
      int               k;
      answer = '0;
      case (item.op)
         cvl_pkg::OP_APPEND: begin
            if (list_len < cvl_pkg::CAPACITY) begin
               list_vals[list_len] = item.value;
               list_len++;
               answer.ok = 1'b1;
            end
         end
         cvl_pkg::OP_REMOVE: begin
            pos = 0;
            while (pos < list_len && list_vals[pos] !== item.value) pos++;
            if (pos < list_len) begin
               for (k = pos + 1; k < list_len; k++) list_vals[k-1] = list_vals[k];
               list_len--;
               answer.ok = 1'b1;
            end
         end
         cvl_pkg::OP_GET: begin
            if (int'(item.index) < list_len) begin
               answer.data = list_vals[item.index];
               answer.ok   = 1'b1;
            end else begin
               answer.data = -1;
            end
         end
         default: begin
            list_len  = 0;
            answer.ok = 1'b1;
         end
      endcase
      answer.count     = list_len[cvl_pkg::COUNT_W-1:0];
      answer.empty_res = (list_len == 0);
      return answer;
   endfunction

   task automatic offer_request(input cvl_pkg::op_type op,
                                input logic signed [cvl_pkg::DATA_W-1:0] value,
                                input logic [cvl_pkg::INDEX_W-1:0] index);
      cvl_pkg::req_type item;
      int               gap;
      item.op    = op;
      item.value = value;
      item.index = index;
      gap = 0;
      if (!steady_flow && $urandom_range(99) < 20) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(apply_list_op(item));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // response side: random stalls, long hold-off on request
   initial begin
      int hold_left;
      int hold_taken;
      hold_left  = 0;
      hold_taken = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_asks) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (reset || steady_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 20);
         end
      end
   end

   task automatic check_field(input string name, input logic [cvl_pkg::DATA_W-1:0] want,
                              input logic [cvl_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cvl_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response beat, expected none, got %0h",
                     $time, rsp_payload);
         end else begin
            want = pending_answers.pop_front();
            check_field("ok", cvl_pkg::DATA_W'(want.ok),
                        cvl_pkg::DATA_W'(rsp_payload.ok));
            check_field("data", want.data, rsp_payload.data);
            check_field("count", cvl_pkg::DATA_W'(want.count),
                        cvl_pkg::DATA_W'(rsp_payload.count));
            check_field("empty_res", cvl_pkg::DATA_W'(want.empty_res),
                        cvl_pkg::DATA_W'(rsp_payload.empty_res));
         end
      end
   end

   task automatic test_basic_ops();
      offer_request(cvl_pkg::OP_CLEAR, 0, 0);
      offer_request(cvl_pkg::OP_GET, 0, 0);
      offer_request(cvl_pkg::OP_REMOVE, DATA_MIN, 0);
      offer_request(cvl_pkg::OP_APPEND, DATA_MIN, 5'd31);
      offer_request(cvl_pkg::OP_APPEND, DATA_MAX, 0);
      offer_request(cvl_pkg::OP_APPEND, -1, 0);
      offer_request(cvl_pkg::OP_APPEND, DATA_MIN, 0);
      offer_request(cvl_pkg::OP_APPEND, 0, 0);
      offer_request(cvl_pkg::OP_GET, DATA_MAX, 0);
      offer_request(cvl_pkg::OP_GET, 0, 3);
      offer_request(cvl_pkg::OP_GET, 0, 4);
      offer_request(cvl_pkg::OP_GET, 0, 5'd31);
      // first of two equal entries goes, later ones move down
      offer_request(cvl_pkg::OP_REMOVE, DATA_MIN, 0);
      offer_request(cvl_pkg::OP_GET, 0, 2);
      offer_request(cvl_pkg::OP_REMOVE, 0, 0);
      offer_request(cvl_pkg::OP_REMOVE, 12345, 0);
      offer_request(cvl_pkg::OP_CLEAR, DATA_MAX, 5'd31);
      offer_request(cvl_pkg::OP_CLEAR, 0, 0);
   endtask

   task automatic test_full_list();
      repeat (cvl_pkg::CAPACITY)
         offer_request(cvl_pkg::OP_APPEND, $urandom,
                       cvl_pkg::INDEX_W'($urandom_range(31)));
      offer_request(cvl_pkg::OP_APPEND, DATA_MAX, 0);
      offer_request(cvl_pkg::OP_GET, 0, cvl_pkg::INDEX_W'(cvl_pkg::CAPACITY - 1));
      offer_request(cvl_pkg::OP_GET, 0, cvl_pkg::INDEX_W'(cvl_pkg::CAPACITY));
      // head removal moves every later entry
      offer_request(cvl_pkg::OP_REMOVE, list_vals[0], 0);
      offer_request(cvl_pkg::OP_REMOVE, list_vals[list_len-1], 0);
      offer_request(cvl_pkg::OP_CLEAR, 0, 0);
   endtask

   task automatic test_random_mix(input int items, input int append_pct);
      int                                roll;
      cvl_pkg::op_type                   op;
      logic signed [cvl_pkg::DATA_W-1:0] value;
      logic [cvl_pkg::INDEX_W-1:0]       index;
      repeat (items) begin
         roll  = $urandom_range(99);
         value = ($urandom_range(1) == 1) ? $urandom : $urandom_range(6) - 3;
         index = cvl_pkg::INDEX_W'($urandom_range(31));
         if (roll < append_pct) begin
            op = cvl_pkg::OP_APPEND;
         end else if (roll < append_pct + 30) begin
            op = cvl_pkg::OP_REMOVE;
            if (list_len > 0 && $urandom_range(3) != 0)
               value = list_vals[$urandom_range(list_len - 1)];
         end else if (roll < 97) begin
            op = cvl_pkg::OP_GET;
            if (list_len > 0 && $urandom_range(4) != 0)
               index = cvl_pkg::INDEX_W'($urandom_range(list_len - 1));
         end else begin
            op = cvl_pkg::OP_CLEAR;
         end
         offer_request(op, value, index);
      end
   endtask

   task automatic test_backpressure();
      steady_flow = 1'b1;
      hold_asks++;
      test_random_mix(24, 60);
      wait_drained();
      steady_flow = 1'b0;
   endtask

   task automatic test_steady_stream();
      steady_flow = 1'b1;
      test_random_mix(200, 45);
      wait_drained();
      steady_flow = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_full_list();
      test_backpressure();
      test_steady_stream();
      test_random_mix(350, 55);
      wait_drained();
      test_random_mix(330, 30);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("compacting_value_list_top_tb: clean");
      end else begin
         $display("compacting_value_list_top_tb: errors");
      end
      $finish;
   end

endmodule
